// ===== rtl/rs485_pkg.sv =====
// shared types and constants for the rs485 half-duplex link controller
package rs485_pkg;

  localparam int RING_DEPTH_DEF = 128;
  localparam int BackoffW = 16;
  localparam logic [BackoffW-1:0] BACKOFF_RESET = 16'd750;
  localparam logic [2:0] ERR_MASK = 3'h7;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_POP   = 2'd2;
  localparam logic [1:0] OP_RESET = 2'd3;

  localparam logic [1:0] LS_IDLE  = 2'd0;
  localparam logic [1:0] LS_XFER  = 2'd1;
  localparam logic [1:0] LS_RECV  = 2'd2;
  localparam logic [1:0] LS_ERROR = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_WAIT    = 7'b0000010,
    ST_RECV    = 7'b0000100,
    ST_XFER    = 7'b0001000,
    ST_WCOMP   = 7'b0010000,
    ST_ERR     = 7'b0100000,
    ST_ERRIDLE = 7'b1000000
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] host_byte;
    logic       uart_rx_ready;
    logic [7:0] uart_rx_byte;
    logic       uart_tx_full;
    logic       uart_tx_empty;
    logic [2:0] uart_error_bits;
  } in_word_t;

  typedef struct packed {
    logic       uart_write;
    logic [7:0] uart_write_byte;
    logic       drive_enable;
    logic       uart_enable;
    logic [1:0] link_status;
    logic       host_rx_valid;
    logic [7:0] host_rx_byte;
    logic       rx_has_data;
    logic       link_idle;
    logic [2:0] latched_errors;
    logic       overflow_drop;
  } out_word_t;

endpackage

// ===== rtl/rs485_if.sv =====
// valid/ready channel interfaces for input and result words
interface rs485_in_if import rs485_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rs485_out_if import rs485_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rs485_half_duplex_link_control.sv =====
// rs485 half-duplex link controller: tx/rx rings in memory, control fsm, backoff
//
//  channel  dir  handshake     word
//  req      in   valid/ready   in_word_t   host opcode and uart status
//  rsp      out  valid/ready   out_word_t  uart write, direction, status, popped byte
//  cfg      in   cfg_we        16 bit      backoff_ticks
//
//  one word accepted per cycle; its result appears in the next cycle, after the
//  ring memory read (one read and one write port per ring)
//  rst is synchronous and clears pointers, fsm, latch and the output stage
//  a stalled result holds the output stage and stops acceptance of new words
module rs485_half_duplex_link_control import rs485_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [BackoffW-1:0] cfg_wdata,
  rs485_in_if.sink            req,
  rs485_out_if.source         rsp
);

  localparam int PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] i);
    return (i == PtrW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  ctrl_state_t         state, state_next;
  logic [1:0]          status, status_next;
  logic [PtrW-1:0]     tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [PtrW-1:0]     rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [BackoffW-1:0] backoff_left, backoff_left_next, backoff_ticks;
  logic [2:0]          error_latch, error_latch_next;
  logic                direction, direction_next;
  logic                uart_on, uart_on_next;

  logic [7:0] tx_mem [RING_DEPTH];
  logic [7:0] rx_mem [RING_DEPTH];
  logic [7:0] tx_rd_q, rx_rd_q, fwd_byte;
  logic       fwd;

  logic       accept, tx_we, rx_we, wr, pop, drop, tx_avail;
  out_word_t  pend;
  logic       pend_valid;
  in_word_t   w;

  assign w      = req.data;
  assign accept = req.valid && req.ready;
  assign req.ready = !pend_valid || rsp.ready;

  always_comb begin
    state_next        = state;
    status_next       = status;
    tx_head_next      = tx_head;
    tx_tail_next      = tx_tail;
    rx_head_next      = rx_head;
    rx_tail_next      = rx_tail;
    error_latch_next  = error_latch;
    direction_next    = direction;
    uart_on_next      = uart_on;
    backoff_left_next = (backoff_left != '0) ? backoff_left - 1'b1 : backoff_left;
    wr       = 1'b0;
    pop      = 1'b0;
    drop     = 1'b0;
    tx_we    = 1'b0;
    rx_we    = 1'b0;
    tx_avail = 1'b0;
    if (w.opcode == OP_RESET) begin
      state_next       = ST_IDLE;
      status_next      = LS_IDLE;
      tx_head_next     = '0;
      tx_tail_next     = '0;
      rx_head_next     = '0;
      rx_tail_next     = '0;
      error_latch_next = '0;
      direction_next   = 1'b0;
      uart_on_next     = 1'b1;
    end else begin
      if (w.opcode == OP_PUSH) begin
        if (ring_next(tx_head) == tx_tail) begin
          drop = 1'b1;
        end else begin
          tx_we        = 1'b1;
          tx_head_next = ring_next(tx_head);
        end
      end else if (w.opcode == OP_POP) begin
        if (rx_head != rx_tail) begin
          pop          = 1'b1;
          rx_tail_next = ring_next(rx_tail);
        end
      end
      tx_avail = (tx_head_next != tx_tail) && !w.uart_tx_full;
      unique case (state)
        ST_WAIT: begin
          if (w.uart_rx_ready) begin
            status_next = LS_RECV;
            state_next  = ST_RECV;
          end else if (tx_avail && backoff_left_next == '0) begin
            status_next = LS_XFER;
            state_next  = ST_XFER;
          end else begin
            error_latch_next = (error_latch | w.uart_error_bits) & ERR_MASK;
            if (error_latch_next != '0) begin
              state_next = ST_ERR;
            end
          end
        end
        ST_RECV: begin
          backoff_left_next = backoff_ticks;
          if (w.uart_rx_ready) begin
            if (ring_next(rx_head) == rx_tail_next) begin
              drop = 1'b1;
            end else begin
              rx_we        = 1'b1;
              rx_head_next = ring_next(rx_head);
            end
          end else begin
            state_next = ST_IDLE;
          end
        end
        ST_XFER: begin
          direction_next = 1'b1;
          if (tx_avail) begin
            wr           = 1'b1;
            tx_tail_next = ring_next(tx_tail);
          end
          state_next = ST_WCOMP;
        end
        ST_WCOMP: begin
          if (tx_avail) begin
            state_next = ST_XFER;
          end else if (w.uart_tx_empty) begin
            direction_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end
        ST_ERR: begin
          uart_on_next = 1'b0;
          status_next  = LS_ERROR;
          state_next   = ST_ERRIDLE;
        end
        ST_ERRIDLE: begin
        end
        default: begin
          direction_next = 1'b0;
          status_next    = LS_IDLE;
          state_next     = ST_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      status        <= LS_IDLE;
      tx_head       <= '0;
      tx_tail       <= '0;
      rx_head       <= '0;
      rx_tail       <= '0;
      backoff_left  <= '0;
      error_latch   <= '0;
      direction     <= 1'b0;
      uart_on       <= 1'b1;
      backoff_ticks <= BACKOFF_RESET;
      pend_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        backoff_ticks <= cfg_wdata;
      end
      if (accept) begin
        state        <= state_next;
        status       <= status_next;
        tx_head      <= tx_head_next;
        tx_tail      <= tx_tail_next;
        rx_head      <= rx_head_next;
        rx_tail      <= rx_tail_next;
        backoff_left <= backoff_left_next;
        error_latch  <= error_latch_next;
        direction    <= direction_next;
        uart_on      <= uart_on_next;
        pend_valid   <= 1'b1;
      end else if (rsp.ready) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // ring memories, registered read
  always_ff @(posedge clk) begin
    if (accept && tx_we) begin
      tx_mem[tx_head] <= w.host_byte;
    end
    if (accept && wr) begin
      tx_rd_q <= tx_mem[tx_tail];
    end
    if (accept && rx_we) begin
      rx_mem[rx_head] <= w.uart_rx_byte;
    end
    if (accept && pop) begin
      rx_rd_q <= rx_mem[rx_tail];
    end
  end

  // result stage, bytes come from the memory read, or from the host byte when it is pushed into the tx slot being read
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd                  <= tx_we && wr && (tx_head == tx_tail);
      fwd_byte             <= w.host_byte;
      pend.uart_write      <= wr;
      pend.uart_write_byte <= '0;
      pend.drive_enable    <= direction_next;
      pend.uart_enable     <= uart_on_next;
      pend.link_status     <= status_next;
      pend.host_rx_valid   <= pop;
      pend.host_rx_byte    <= '0;
      pend.rx_has_data     <= rx_head_next != rx_tail_next;
      pend.link_idle       <= (status_next == LS_IDLE && tx_head_next == tx_tail_next)
                              || status_next == LS_ERROR;
      pend.latched_errors  <= error_latch_next;
      pend.overflow_drop   <= drop;
    end
  end

  always_comb begin
    rsp.data = pend;
    rsp.data.uart_write_byte = pend.uart_write ? (fwd ? fwd_byte : tx_rd_q) : 8'h00;
    rsp.data.host_rx_byte    = pend.host_rx_valid ? rx_rd_q : 8'h00;
  end
  assign rsp.valid = pend_valid;

  a_dir_in_tx: assert property (@(posedge clk) disable iff (rst)
    direction |-> (state == ST_XFER || state == ST_WCOMP))
    else $error("drive enable outside transmit states");

  a_uart_off_parked: assert property (@(posedge clk) disable iff (rst)
    (!uart_on || error_latch != '0) |-> (state == ST_ERR || state == ST_ERRIDLE))
    else $error("latched error or disabled uart without error state");

  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !rsp.ready) |=> ($stable(tx_rd_q) && $stable(rx_rd_q) && $stable(fwd)))
    else $error("read data changed under a stalled word");

endmodule
